// ----- rtl/vabi_pkg.sv -----
// Package for the video/audio byte interleaver: sizes, register indexes,
// reset values and the structs shared by the modules. No dependencies.
package vabi_pkg;

  // Width of the internal read offset counters.
  localparam int OFFSET_BITS = 24;
  // Width of the offset field of a result and of the store length registers.
  localparam int OUT_BITS    = 24;
  localparam int LEN_BITS    = 24;
  localparam int CMP_BITS    = (OFFSET_BITS > LEN_BITS) ? OFFSET_BITS : LEN_BITS;
  localparam int POS_BITS    = 12;
  localparam int GAP_BITS    = 5;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BITMAP_LENGTH  = 3'd0,
    REG_AUDIO_LENGTH   = 3'd1,
    REG_FIRST_REGION   = 3'd2,
    REG_FIRST_STRIDE   = 3'd3,
    REG_SECOND_REGION  = 3'd4,
    REG_SECOND_STRIDE  = 3'd5,
    REG_TAIL_AUDIO     = 3'd6
  } cfg_reg_e;

  localparam logic [LEN_BITS-1:0] RST_BITMAP_LENGTH = LEN_BITS'(22 * 16 * 10);
  localparam logic [LEN_BITS-1:0] RST_AUDIO_LENGTH  = LEN_BITS'(4096);
  localparam logic [POS_BITS-1:0] RST_FIRST_REGION  = POS_BITS'(22 * 16 * 8);
  localparam logic [GAP_BITS-1:0] RST_FIRST_STRIDE  = GAP_BITS'(16);
  localparam logic [POS_BITS-1:0] RST_SECOND_REGION = POS_BITS'(22 * 16 * 2);
  localparam logic [GAP_BITS-1:0] RST_SECOND_STRIDE = GAP_BITS'(24);
  localparam logic [GAP_BITS-1:0] RST_TAIL_AUDIO    = GAP_BITS'(23);

  typedef struct packed {
    logic [LEN_BITS-1:0] bitmap_length;
    logic [LEN_BITS-1:0] audio_length;
    logic [POS_BITS-1:0] first_region_bytes;
    logic [GAP_BITS-1:0] first_stride;
    logic [POS_BITS-1:0] second_region_bytes;
    logic [GAP_BITS-1:0] second_stride;
    logic [GAP_BITS-1:0] tail_audio_count;
  } cfg_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] bitmap_offset;
    logic [OFFSET_BITS-1:0] audio_offset;
    logic [POS_BITS-1:0]    frame_position;
    logic [GAP_BITS-1:0]    first_gap_count;
    logic [GAP_BITS-1:0]    second_gap_count;
    logic [GAP_BITS-1:0]    audio_pending;
  } state_t;

endpackage

// ----- rtl/vabi_intf.sv -----
// Channel interfaces of the interleaver: strobe input, result output and
// configuration write. Depends on vabi_pkg for the field widths.
interface vabi_in_if;
  logic valid;
  logic ready;
  logic select_high;
  modport source (output valid, output select_high, input ready);
  modport sink   (input valid, input select_high, output ready);
endinterface

interface vabi_out_if;
  logic                         valid;
  logic                         ready;
  logic                         from_audio;
  logic [vabi_pkg::OUT_BITS-1:0] read_offset;
  modport source (output valid, output from_audio, output read_offset, input ready);
  modport sink   (input valid, input from_audio, input read_offset, output ready);
endinterface

interface vabi_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [vabi_pkg::CFG_IDX_BITS-1:0]  index;
  logic [vabi_pkg::CFG_DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/vabi_cfg.sv -----
// Configuration register file of the interleaver.
// Depends on vabi_pkg and the configuration channel in vabi_intf.
module vabi_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  vabi_cfg_if.sink        cfg_i,
  output vabi_pkg::cfg_t  cfg_o
);
  import vabi_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_BITMAP_LENGTH: cfg_d.bitmap_length       = cfg_i.data[LEN_BITS-1:0];
        REG_AUDIO_LENGTH:  cfg_d.audio_length        = cfg_i.data[LEN_BITS-1:0];
        REG_FIRST_REGION:  cfg_d.first_region_bytes  = cfg_i.data[POS_BITS-1:0];
        REG_FIRST_STRIDE:  cfg_d.first_stride        = cfg_i.data[GAP_BITS-1:0];
        REG_SECOND_REGION: cfg_d.second_region_bytes = cfg_i.data[POS_BITS-1:0];
        REG_SECOND_STRIDE: cfg_d.second_stride       = cfg_i.data[GAP_BITS-1:0];
        REG_TAIL_AUDIO:    cfg_d.tail_audio_count    = cfg_i.data[GAP_BITS-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bitmap_length       <= RST_BITMAP_LENGTH;
      cfg_q.audio_length        <= RST_AUDIO_LENGTH;
      cfg_q.first_region_bytes  <= RST_FIRST_REGION;
      cfg_q.first_stride        <= RST_FIRST_STRIDE;
      cfg_q.second_region_bytes <= RST_SECOND_REGION;
      cfg_q.second_stride       <= RST_SECOND_STRIDE;
      cfg_q.tail_audio_count    <= RST_TAIL_AUDIO;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/vabi_step.sv -----
// Next-state and result logic for one port strobe of the interleaver.
// Purely combinational; depends on vabi_pkg.
module vabi_step (
  input  vabi_pkg::cfg_t                 cfg_i,
  input  vabi_pkg::state_t               state_i,
  input  logic                           select_high_i,
  output vabi_pkg::state_t               state_o,
  output logic                           from_audio_o,
  output logic [vabi_pkg::OUT_BITS-1:0]  read_offset_o
);
  import vabi_pkg::*;

  logic [POS_BITS:0]      region_end;
  logic [OFFSET_BITS-1:0] bitmap_inc;
  logic [OFFSET_BITS-1:0] audio_inc;
  logic [GAP_BITS-1:0]    first_gap_inc;
  logic [GAP_BITS-1:0]    second_gap_inc;
  logic [CMP_BITS-1:0]    out_ext;

  assign region_end     = {1'b0, cfg_i.first_region_bytes} + {1'b0, cfg_i.second_region_bytes};
  assign bitmap_inc     = state_i.bitmap_offset + OFFSET_BITS'(1);
  assign audio_inc      = state_i.audio_offset + OFFSET_BITS'(1);
  assign first_gap_inc  = state_i.first_gap_count + GAP_BITS'(1);
  assign second_gap_inc = state_i.second_gap_count + GAP_BITS'(1);

  always_comb begin
    state_o      = state_i;
    from_audio_o = 1'b0;
    out_ext      = CMP_BITS'(state_i.bitmap_offset);
    if (!select_high_i) begin
      state_o = '0;
    end else if (state_i.audio_pending != '0) begin
      // Audio byte owed: serve it and advance the audio offset only.
      from_audio_o          = 1'b1;
      out_ext               = CMP_BITS'(state_i.audio_offset);
      state_o.audio_pending = state_i.audio_pending - GAP_BITS'(1);
      state_o.audio_offset  = audio_inc;
      if (CMP_BITS'(audio_inc) >= CMP_BITS'(cfg_i.audio_length)) begin
        state_o.audio_offset = '0;
      end
    end else begin
      if (state_i.frame_position < cfg_i.first_region_bytes) begin
        state_o.frame_position  = state_i.frame_position + POS_BITS'(1);
        state_o.bitmap_offset   = bitmap_inc;
        state_o.first_gap_count = first_gap_inc;
        if (first_gap_inc >= cfg_i.first_stride) begin
          state_o.audio_pending   = GAP_BITS'(1);
          state_o.first_gap_count = '0;
        end
      end else if ({1'b0, state_i.frame_position} < region_end) begin
        state_o.frame_position   = state_i.frame_position + POS_BITS'(1);
        state_o.bitmap_offset    = bitmap_inc;
        state_o.second_gap_count = second_gap_inc;
        if (second_gap_inc >= cfg_i.second_stride) begin
          state_o.audio_pending    = GAP_BITS'(1);
          state_o.second_gap_count = '0;
        end
      end else begin
        // End of frame: the bitmap byte repeats and the audio burst is queued.
        state_o.frame_position   = '0;
        state_o.first_gap_count  = '0;
        state_o.second_gap_count = '0;
        state_o.audio_pending    = cfg_i.tail_audio_count;
      end
      if (CMP_BITS'(state_o.bitmap_offset) >= CMP_BITS'(cfg_i.bitmap_length)) begin
        state_o.bitmap_offset  = '0;
        state_o.frame_position = '0;
      end
    end
  end

  assign read_offset_o = out_ext[OUT_BITS-1:0];

endmodule

// ----- rtl/video_audio_byte_interleaver.sv -----
// Top level of the video/audio byte interleaver: configuration registers,
// counter state and the result register. Depends on vabi_pkg, vabi_intf,
// vabi_cfg and vabi_step.

// The interleaver takes one transaction per strobe of the byte port, one per
// clock cycle when the result side keeps up: every accepted transaction is
// processed in the cycle it is accepted, its counters update at that clock
// edge and its result lands in a single output register. A transaction with
// select_high low clears all counters and both offsets and produces no
// result; one with select_high high produces exactly one result naming the
// store (bitmap or audio) and the offset to read. The input is ready whenever
// the output register is empty or is being drained in the same cycle, so
// throughput is set by that one register, which holds each result until taken.
// Configuration writes are always accepted and should only be issued while
// no result is outstanding; unknown register indexes are ignored.
module video_audio_byte_interleaver (
  input  logic       clk_i,
  input  logic       rst_ni,
  vabi_in_if.sink    in_i,
  vabi_out_if.source out_o,
  vabi_cfg_if.sink   cfg_i
);
  import vabi_pkg::*;

  cfg_t                cfg;
  state_t              state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                from_audio_q, from_audio_d;
  logic [OUT_BITS-1:0] read_offset_q, read_offset_d;
  logic                in_fire;
  logic                out_fire;

  vabi_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  vabi_step u_step (
    .cfg_i         (cfg),
    .state_i       (state_q),
    .select_high_i (in_i.select_high),
    .state_o       (state_d),
    .from_audio_o  (from_audio_d),
    .read_offset_o (read_offset_d)
  );

  // The result register frees up in the same cycle it is drained.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_fire) begin
      out_valid_d = 1'b0;
    end
    if (in_fire && in_i.select_high) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.select_high) begin
      from_audio_q  <= from_audio_d;
      read_offset_q <= read_offset_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.from_audio  = from_audio_q;
  assign out_o.read_offset = read_offset_q;

  // A select-low transaction leaves every counter and offset at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_i.select_high |=> state_q == '0)
    else $error("counters not cleared by select-low transaction");

  // A serving transaction always leaves a result waiting in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.select_high |=> out_valid_q)
    else $error("serving transaction produced no result");

  // An owed audio byte is served before any bitmap byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.select_high && state_q.audio_pending != '0 |=> from_audio_q)
    else $error("bitmap byte served while audio was pending");

  // With nothing owed, the byte comes from the bitmap store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.select_high && state_q.audio_pending == '0 |=> !from_audio_q)
    else $error("audio byte served with nothing pending");

endmodule
